// ===== rtl/core/brl_pkg.sv =====
// Shared types and constants for the Bresenham line rasterizer.
package brl_pkg;

  localparam int CoordBits = 16;
  localparam int ColorBits = 32;
  localparam int RegBits   = 11;
  localparam int IndexBits = 20;
  localparam int ErrBits   = 20;
  localparam int StepBits  = 17;
  localparam int TwiceBits = 18;
  localparam int RowBits   = 18;

  localparam logic [RegBits-1:0] MaxCanvasWidth  = 11'd1024;
  localparam logic [RegBits-1:0] MaxCanvasHeight = 11'd1024;
  localparam logic [RegBits-1:0] ResetWidth      = 11'd640;
  localparam logic [RegBits-1:0] ResetHeight     = 11'd480;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  typedef enum logic [0:0] {
    CFG_CANVAS_WIDTH  = 1'b0,
    CFG_CANVAS_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                        command;
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
    logic [ColorBits-1:0]        line_color;
  } cmd_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic                        visible;
    logic [IndexBits-1:0]        write_index;
    logic [ColorBits-1:0]        pixel_value;
    logic                        last_point;
  } pt_t;

endpackage

// ===== rtl/core/brl_cmd_if.sv =====
// Request channel that carries start and step commands into the rasterizer.
interface brl_cmd_if;
  import brl_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/brl_pt_if.sv =====
// Request channel that carries rasterized line points out of the rasterizer.
interface brl_pt_if;
  import brl_pkg::*;

  logic valid;
  logic ready;
  pt_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bresenham_line_rasterizer_core.sv =====
// Top level of the Bresenham line rasterizer with canvas clipping.
//
// A start request on cmd_i loads two endpoints and a color and gives no point.
// Each later step request gives one point on pt_o, from the start endpoint to
// the end endpoint, with its frame-buffer index and a flag on the last point.
// A step request with no line in progress is taken and gives nothing.
// The canvas width and height are written through cfg_we_i, cfg_idx_i and
// cfg_data_i while the block is idle; the user must keep to this, as the
// block does not enforce it. Values above 1024 saturate. Throughput is one
// request per cycle; when the receiver stalls, cmd_i.ready stays high only
// if the result register is empty or drained in that cycle, so nothing is
// lost. A point appears on pt_o in the cycle after its step request is
// taken, held in the result register; the line state advances in the same
// cycle, so the error update and the index multiply of one point fit
// between the state and result registers. Reset empties the result
// register, ends any line in progress and restores a 640 by 480 canvas.
module bresenham_line_rasterizer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  brl_cmd_if.sink                         cmd_i,
  brl_pt_if.source                        pt_o,
  input  logic                            cfg_we_i,
  input  brl_pkg::cfg_reg_e               cfg_idx_i,
  input  logic [brl_pkg::RegBits-1:0]     cfg_data_i
);
  import brl_pkg::*;

  logic [RegBits-1:0]          width_q, width_d;
  logic [RegBits-1:0]          height_q, height_d;
  logic                        active_q, active_d;
  logic                        out_valid_q, out_valid_d;
  logic signed [CoordBits-1:0] cur_x_q, cur_x_d;
  logic signed [CoordBits-1:0] cur_y_q, cur_y_d;
  logic signed [ErrBits-1:0]   err_q, err_d;
  logic [StepBits-1:0]         steps_q, steps_d;
  logic [TwiceBits-1:0]        tminor_q, tminor_d;
  logic [TwiceBits-1:0]        tmajor_q, tmajor_d;
  logic [1:0]                  signs_q, signs_d;
  logic                        y_major_q, y_major_d;
  logic [ColorBits-1:0]        color_q, color_d;
  pt_t                         pt_q, pt_d;

  logic                        in_acc;
  logic                        produce;
  logic signed [StepBits-1:0]  dx, dy;
  logic [StepBits-1:0]         adx, ady, major, minor;
  logic                        start_y_major;
  logic signed [ErrBits-1:0]   e_add, e_sub;
  logic                        e_pos;
  logic signed [CoordBits-1:0] x_adv, y_adv;
  logic signed [RowBits-1:0]   flip_y;
  logic                        vis;
  logic [IndexBits:0]          idx_sum;
  logic                        last;

  assign cmd_i.ready = ~out_valid_q | pt_o.ready;
  assign in_acc      = cmd_i.valid & cmd_i.ready;
  assign produce     = in_acc & (cmd_i.data.command == CmdStep) & active_q;
  assign pt_o.valid  = out_valid_q;
  assign pt_o.data   = pt_q;

  // Line setup from the two endpoints.
  always_comb begin
    dx = {cmd_i.data.end_x[CoordBits-1], cmd_i.data.end_x}
       - {cmd_i.data.start_x[CoordBits-1], cmd_i.data.start_x};
    dy = {cmd_i.data.end_y[CoordBits-1], cmd_i.data.end_y}
       - {cmd_i.data.start_y[CoordBits-1], cmd_i.data.start_y};
    adx = dx[StepBits-1] ? (~dx + 1'b1) : dx;
    ady = dy[StepBits-1] ? (~dy + 1'b1) : dy;
    start_y_major = adx < ady;
    major = start_y_major ? ady : adx;
    minor = start_y_major ? adx : ady;
  end

  // One Bresenham iteration and the clipped point of the current position.
  always_comb begin
    e_add  = err_q + $signed({2'b00, tminor_q});
    e_pos  = ~e_add[ErrBits-1] & (|e_add);
    e_sub  = e_add - $signed({2'b00, tmajor_q});
    x_adv  = signs_q[0] ? (cur_x_q - 16'sd1) : (cur_x_q + 16'sd1);
    y_adv  = signs_q[1] ? (cur_y_q - 16'sd1) : (cur_y_q + 16'sd1);
    flip_y = $signed({7'b0, height_q}) - {{2{cur_y_q[CoordBits-1]}}, cur_y_q} - 18'sd1;
    vis    = ~cur_x_q[CoordBits-1]
           & ({1'b0, cur_x_q[CoordBits-2:0]} < {5'b0, width_q})
           & ~flip_y[RowBits-1]
           & (flip_y[RowBits-2:0] < {6'b0, height_q});
    idx_sum = ({10'b0, width_q} * {11'b0, flip_y[9:0]}) + {11'b0, cur_x_q[9:0]};
    last    = (steps_q == '0);
  end

  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    active_d    = active_q;
    out_valid_d = out_valid_q & ~pt_o.ready;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    err_d       = err_q;
    steps_d     = steps_q;
    tminor_d    = tminor_q;
    tmajor_d    = tmajor_q;
    signs_d     = signs_q;
    y_major_d   = y_major_q;
    color_d     = color_q;
    pt_d        = pt_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CANVAS_WIDTH: begin
          width_d = (cfg_data_i > MaxCanvasWidth) ? MaxCanvasWidth : cfg_data_i;
        end
        CFG_CANVAS_HEIGHT: begin
          height_d = (cfg_data_i > MaxCanvasHeight) ? MaxCanvasHeight : cfg_data_i;
        end
        default: begin
        end
      endcase
    end

    if (in_acc && (cmd_i.data.command == CmdStart)) begin
      y_major_d = start_y_major;
      tmajor_d  = {major, 1'b0};
      tminor_d  = {minor, 1'b0};
      err_d     = -$signed({3'b000, major});
      steps_d   = major;
      signs_d   = {~(cmd_i.data.start_y < cmd_i.data.end_y),
                   ~(cmd_i.data.start_x < cmd_i.data.end_x)};
      cur_x_d   = cmd_i.data.start_x;
      cur_y_d   = cmd_i.data.start_y;
      color_d   = cmd_i.data.line_color;
      active_d  = 1'b1;
    end else if (produce) begin
      out_valid_d         = 1'b1;
      pt_d.point_x        = cur_x_q;
      pt_d.point_y        = cur_y_q;
      pt_d.visible        = vis;
      pt_d.write_index    = vis ? idx_sum[IndexBits-1:0] : '0;
      pt_d.pixel_value    = color_q;
      pt_d.last_point     = last;
      if (last) begin
        active_d = 1'b0;
      end else begin
        steps_d = steps_q - 1'b1;
        err_d   = e_pos ? e_sub : e_add;
        if (y_major_q) begin
          cur_y_d = y_adv;
          if (e_pos) begin
            cur_x_d = x_adv;
          end
        end else begin
          cur_x_d = x_adv;
          if (e_pos) begin
            cur_y_d = y_adv;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= ResetWidth;
      height_q    <= ResetHeight;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      err_q       <= '0;
      steps_q     <= '0;
      tminor_q    <= '0;
      tmajor_q    <= '0;
      signs_q     <= '0;
      y_major_q   <= 1'b0;
      color_q     <= '0;
      pt_q        <= '0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      err_q       <= err_d;
      steps_q     <= steps_d;
      tminor_q    <= tminor_d;
      tmajor_q    <= tmajor_d;
      signs_q     <= signs_d;
      y_major_q   <= y_major_d;
      color_q     <= color_d;
      pt_q        <= pt_d;
    end
  end

endmodule

// ===== rtl/core/brl_checker.sv =====
// Port-level checker for the Bresenham line rasterizer and its bind.
module brl_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          in_command_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input brl_pkg::pt_t  out_data_i
);
  import brl_pkg::*;

  // A stalled point keeps its contents until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("stalled point changed");

  // A start request never produces a point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == CmdStart) |=> !out_valid_i)
    else $error("start request produced a point");

  // A clipped point carries a zero index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.visible |-> (out_data_i.write_index == '0))
    else $error("clipped point has nonzero index");

  // A full, stalled result register holds off new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken while output stalled");

endmodule

bind bresenham_line_rasterizer_core brl_checker u_brl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (cmd_i.valid),
  .in_ready_i   (cmd_i.ready),
  .in_command_i (cmd_i.data.command),
  .out_valid_i  (pt_o.valid),
  .out_ready_i  (pt_o.ready),
  .out_data_i   (pt_o.data)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the Bresenham line rasterizer core.
`timescale 1ns / 100ps

module testbench;
  import brl_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int PhaseCount = 8;
  localparam int PhaseBudget = 90;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cfg_reg_e cfg_idx_i;
  logic [RegBits-1:0] cfg_data_i;

  brl_cmd_if cmd_ch ();
  brl_pt_if pt_ch ();

  bresenham_line_rasterizer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_ch),
    .pt_o       (pt_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  cmd_t cmd_backlog[$];
  pt_t pending_points[$];

  logic [RegBits-1:0] canvas_w = ResetWidth;
  logic [RegBits-1:0] canvas_h = ResetHeight;
  logic line_active = 1'b0;
  logic signed [CoordBits-1:0] pos_x = '0;
  logic signed [CoordBits-1:0] pos_y = '0;
  logic signed [ErrBits-1:0] err_acc = '0;
  logic [StepBits-1:0] points_left = '0;
  logic [TwiceBits-1:0] dbl_minor = '0;
  logic [TwiceBits-1:0] dbl_major = '0;
  logic [1:0] step_dir = '0;
  logic y_leads = 1'b0;
  logic [ColorBits-1:0] line_rgb = '0;

  logic cmd_took = 1'b0;
  logic no_gaps = 1'b0;
  logic sink_paused = 1'b0;
  int phase_no = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int unexpected = 0;
  int n_starts = 0;
  int n_steps = 0;
  int n_points = 0;
  int n_visible = 0;
  int n_lasts = 0;
  int n_cfg_writes = 0;
  pt_t want;
  pt_t got;
  logic progress;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic advance_raster(input cmd_t c);
    int x1, y1, x2, y2, adx, ady, maj, mnr, col, row, fy;
    logic vis;
    logic signed [CoordBits-1:0] xs, ys;
    pt_t p;
    if (c.command == CmdStart) begin
      n_starts++;
      x1 = int'($signed(c.start_x));
      y1 = int'($signed(c.start_y));
      x2 = int'($signed(c.end_x));
      y2 = int'($signed(c.end_y));
      adx = (x2 > x1) ? x2 - x1 : x1 - x2;
      ady = (y2 > y1) ? y2 - y1 : y1 - y2;
      y_leads = adx < ady;
      maj = y_leads ? ady : adx;
      mnr = y_leads ? adx : ady;
      dbl_major = TwiceBits'(2 * maj);
      dbl_minor = TwiceBits'(2 * mnr);
      err_acc = ErrBits'(-maj);
      points_left = StepBits'(maj);
      step_dir = {y1 >= y2, x1 >= x2};
      pos_x = c.start_x;
      pos_y = c.start_y;
      line_rgb = c.line_color;
      line_active = 1'b1;
    end else begin
      n_steps++;
      if (line_active) begin
        col = int'(pos_x);
        row = int'(pos_y);
        fy = int'(canvas_h) - row - 1;
        vis = (col >= 0) && (col < int'(canvas_w)) && (fy >= 0) && (fy < int'(canvas_h));
        p.point_x = pos_x;
        p.point_y = pos_y;
        p.visible = vis;
        p.write_index = vis ? IndexBits'(int'(canvas_w) * fy + col) : '0;
        p.pixel_value = line_rgb;
        p.last_point = (points_left == '0);
        pending_points.push_back(p);
        if (points_left == '0) begin
          line_active = 1'b0;
        end else begin
          xs = step_dir[0] ? -16'sd1 : 16'sd1;
          ys = step_dir[1] ? -16'sd1 : 16'sd1;
          err_acc = err_acc + $signed({2'b00, dbl_minor});
          if (y_leads) begin
            pos_y = pos_y + ys;
            if (err_acc > 0) begin
              pos_x = pos_x + xs;
              err_acc = err_acc - $signed({2'b00, dbl_major});
            end
          end else begin
            pos_x = pos_x + xs;
            if (err_acc > 0) begin
              pos_y = pos_y + ys;
              err_acc = err_acc - $signed({2'b00, dbl_major});
            end
          end
          points_left = points_left - 1'b1;
        end
      end
    end
  endtask

  function automatic int spread(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int rand_coord();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void push_start(int x1, int y1, int x2, int y2,
                                     logic [ColorBits-1:0] rgb);
    cmd_t c;
    c.command = CmdStart;
    c.start_x = 16'(x1);
    c.start_y = 16'(y1);
    c.end_x = 16'(x2);
    c.end_y = 16'(y2);
    c.line_color = rgb;
    cmd_backlog.push_back(c);
  endfunction

  function automatic void push_steps(int n);
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      c.command = CmdStep;
      c.start_x = 16'($urandom);
      c.start_y = 16'($urandom);
      c.end_x = 16'($urandom);
      c.end_y = 16'($urandom);
      c.line_color = $urandom;
      cmd_backlog.push_back(c);
    end
  endfunction

  // Mostly whole short lines near the canvas; some cut short, some overrun,
  // some far away or spanning the full coordinate range.
  function automatic int queue_random_line(int w, int h);
    int x1, y1, x2, y2, adx, ady, pts, n, mode, r;
    mode = $urandom_range(99);
    if (mode < 72) begin
      x1 = spread(-4, w + 3);
      y1 = spread(-4, h + 3);
      x2 = x1 + spread(-12, 12);
      y2 = y1 + spread(-12, 12);
    end else if (mode < 86) begin
      x1 = rand_coord();
      y1 = rand_coord();
      x2 = clamp16(x1 + spread(-8, 8));
      y2 = clamp16(y1 + spread(-8, 8));
    end else begin
      x1 = rand_coord();
      y1 = rand_coord();
      x2 = rand_coord();
      y2 = rand_coord();
    end
    adx = (x2 > x1) ? x2 - x1 : x1 - x2;
    ady = (y2 > y1) ? y2 - y1 : y1 - y2;
    pts = ((adx > ady) ? adx : ady) + 1;
    r = $urandom_range(99);
    if (r < 78) n = pts;
    else if (r < 90) n = spread(0, pts - 1);
    else n = pts + spread(1, 3);
    if (n > 40) n = spread(0, 4);
    push_start(x1, y1, x2, y2, $urandom);
    push_steps(n);
    return n + 1;
  endfunction

  always @(negedge clk_i) begin
    if (cmd_ch.valid && !cmd_took) begin
    end else if (rst_ni && cmd_backlog.size() > 0 && (no_gaps || $urandom_range(99) >= 27)) begin
      cmd_ch.valid <= 1'b1;
      cmd_ch.data <= cmd_backlog[0];
    end else begin
      cmd_ch.valid <= 1'b0;
    end
    cmd_took = 1'b0;
  end

  always @(negedge clk_i) begin
    pt_ch.ready <= rst_ni && !sink_paused && (no_gaps || $urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin
    progress = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CANVAS_WIDTH) begin
          canvas_w = (cfg_data_i > MaxCanvasWidth) ? MaxCanvasWidth : cfg_data_i;
        end else begin
          canvas_h = (cfg_data_i > MaxCanvasHeight) ? MaxCanvasHeight : cfg_data_i;
        end
        n_cfg_writes++;
      end
      if (pt_ch.valid && pt_ch.ready) begin
        progress = 1'b1;
        got = pt_ch.data;
        if (pending_points.size() == 0) begin
          unexpected++;
          if (unexpected <= 10) begin
            $display("tb: unexpected point x=%0d y=%0d vis=%0b idx=%0d color=%h last=%0b",
                     got.point_x, got.point_y, got.visible, got.write_index,
                     got.pixel_value, got.last_point);
          end
        end else begin
          want = pending_points.pop_front();
          n_points++;
          if (want.visible) n_visible++;
          if (want.last_point) n_lasts++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("tb: point %0d expected x=%0d y=%0d vis=%0b idx=%0d color=%h last=%0b",
                       n_points, want.point_x, want.point_y, want.visible,
                       want.write_index, want.pixel_value, want.last_point);
              $display("tb: point %0d actual   x=%0d y=%0d vis=%0b idx=%0d color=%h last=%0b",
                       n_points, got.point_x, got.point_y, got.visible,
                       got.write_index, got.pixel_value, got.last_point);
            end
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        progress = 1'b1;
        advance_raster(cmd_ch.data);
        void'(cmd_backlog.pop_front());
        cmd_took = 1'b1;
      end
    end
    idle_cycles = progress ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("tb: no request moved for %0d cycles", IdleLimit);
    $display("tb: failure");
    $finish;
  end

  // The receiver stops for a long stretch while steps keep coming.
  initial begin
    wait (phase_no == 2);
    repeat (30) @(posedge clk_i);
    sink_paused = 1'b1;
    repeat (90) @(posedge clk_i);
    sink_paused = 1'b0;
  end

  initial begin
    int widths[PhaseCount];
    int heights[PhaseCount];
    int eff_w, eff_h, queued;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    pt_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CANVAS_WIDTH;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    widths = '{640, 2047, 1, 0, 100, spread(0, 2047), spread(0, 2047), 1024};
    heights = '{480, 1024, 1, 300, 0, spread(0, 2047), spread(0, 2047), 1};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        while (cmd_backlog.size() != 0 || pending_points.size() != 0) @(posedge clk_i);
        repeat (4) @(negedge clk_i);
        cfg_we_i <= 1'b1;
        cfg_idx_i <= CFG_CANVAS_WIDTH;
        cfg_data_i <= RegBits'(widths[p]);
        @(negedge clk_i);
        cfg_idx_i <= CFG_CANVAS_HEIGHT;
        cfg_data_i <= RegBits'(heights[p]);
        @(negedge clk_i);
        cfg_we_i <= 1'b0;
      end
      no_gaps = (p == 1);
      phase_no = p;
      eff_w = (widths[p] > 1024) ? 1024 : widths[p];
      eff_h = (heights[p] > 1024) ? 1024 : heights[p];
      if (p == 0) begin
        push_steps(1);
        push_start(5, 5, 5, 5, 32'h0000_0001);
        push_steps(2);
        push_start(0, 0, 3, 1, 32'hA5A5_5A5A);
        push_steps(4);
        push_start(2, 3, 1, 0, 32'h0000_FFFF);
        push_steps(4);
        push_start(639, 0, 639, 0, 32'h1234_5678);
        push_steps(1);
        push_start(640, 480, 639, 479, 32'hFFFF_0000);
        push_steps(2);
        push_start(-1, -1, 0, 0, 32'h00FF_00FF);
        push_steps(2);
        push_start(-32768, -32768, 32767, 32767, 32'hFFFF_FFFF);
        push_steps(2);
        push_start(32767, 32767, -32768, -32768, 32'h0000_0000);
        push_steps(1);
      end
      queued = 0;
      while (queued < PhaseBudget) queued += queue_random_line(eff_w, eff_h);
    end

    while (cmd_backlog.size() != 0 || pending_points.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    $display("tb: %0d line starts and %0d steps gave %0d points, %0d on canvas, %0d line ends",
             n_starts, n_steps, n_points, n_visible, n_lasts);
    $display("tb: %0d canvas settings from zero to saturated, %0d register writes, %0d bad",
             PhaseCount, n_cfg_writes, mismatches + unexpected + pending_points.size());
    if (mismatches == 0 && unexpected == 0 && pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/brl_pkg.sv
rtl/core/brl_cmd_if.sv
rtl/core/brl_pt_if.sv
rtl/core/bresenham_line_rasterizer_core.sv
rtl/core/brl_checker.sv
tb/testbench.sv
